/* sv/consistent_hash_ring_macros.svh */
// Assertion helpers used by the RTL.
`ifndef CONSISTENT_HASH_RING_MACROS_SVH
`define CONSISTENT_HASH_RING_MACROS_SVH

// Same-cycle implication.
`define CHR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/chr_pkg.sv */
package chr_pkg;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int CID_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER    = 3'd0,
    CMD_SELECT      = 3'd1,
    CMD_DEL_CLUSTER = 3'd2,
    CMD_DEL_KEY     = 3'd3,
    CMD_CLEAR       = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_FETCH,
    S_INSERT,
    S_REMOVE,
    S_PURGE,
    S_DONE
  } state_e;

endpackage

/* sv/chr_if.sv */
interface chr_req_if;
  import chr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [CID_W-1:0] cluster_id;

  modport source (output valid, output command, output key, output cluster_id, input ready);
  modport sink   (input valid, input command, input key, input cluster_id, output ready);
endinterface

interface chr_rsp_if;
  import chr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CID_W-1:0]    selected_cluster;

  modport source (output valid, output status, output selected_cluster, input ready);
  modport sink   (input valid, input status, input selected_cluster, output ready);
endinterface

/* sv/consistent_hash_ring.sv */
// Consistent-hash ring: sorted table of (key, cluster) virtual nodes.
// req_i carries command, key and cluster_id; rsp_o returns one item per
// request with status and selected_cluster. Both are valid/ready channels.
// One request is worked on at a time; req_i.ready is high only while idle.
// All work goes through one table memory (one read and one write port,
// registered read data) under a small sequencer. The steps per command:
//   select      : binary search, then fetch of the entry found
//   register    : binary search and fetch; a new key shifts entries to open a slot
//   delete key  : binary search and fetch, then a shift to close the gap
//   delete clust: one compaction pass over the table
//   clear/other : straight to the result (select on an empty table too)
// The sequencer returns to idle after each result before the next request
// is taken. The shifts and the compaction pass move one entry per cycle.
// Finished results sit in an output register, so a new request is
// taken while the previous result waits; a stalled receiver only blocks the
// sequencer when it must hand over the next result.
// Reset empties the table at once (entry count to zero); table contents are
// not cleared and are never read before being written.
`include "consistent_hash_ring_macros.svh"

module consistent_hash_ring #(
  parameter int RING_ENTRIES    = 64,
  parameter int CLUSTER_ID_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  chr_req_if.sink   req_i,
  chr_rsp_if.source rsp_o
);
  import chr_pkg::*;

  localparam int AW = $clog2(RING_ENTRIES);
  localparam int CW = $clog2(RING_ENTRIES + 1);
  localparam int CB = CLUSTER_ID_BITS;
  localparam int EW = KEY_W + CB;
  localparam int MW = (CB > CID_W) ? CB : CID_W;
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] FULL_C = CW'(RING_ENTRIES);

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [CB-1:0]      cid_q, cid_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      wp_q, wp_d;
  logic               pend_q, pend_d;
  status_e            res_status_q, res_status_d;
  logic [CID_W-1:0]   res_sel_q, res_sel_d;
  logic               rsp_valid_q, rsp_valid_d;
  status_e            rsp_status_q, rsp_status_d;
  logic [CID_W-1:0]   rsp_sel_q, rsp_sel_d;

  logic [EW-1:0]      mem_q [RING_ENTRIES];
  logic [EW-1:0]      rd_q;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [EW-1:0]      mem_wdata;

  logic [CW-1:0]      mid;
  logic [KEY_W-1:0]   rd_key;
  logic [CB-1:0]      rd_cid;
  logic [MW-1:0]      cid_wide, sel_wide;
  logic [CB-1:0]      cid_in;
  logic [CID_W-1:0]   sel8;
  logic               go_right, key_hit, full;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_key   = rd_q[EW-1:CB];
  assign rd_cid   = rd_q[CB-1:0];
  assign cid_wide = MW'(req_i.cluster_id);
  assign cid_in   = cid_wide[CB-1:0];
  assign sel_wide = MW'(rd_cid);
  assign sel8     = sel_wide[CID_W-1:0];
  assign go_right = (cmd_q == CMD_SELECT) ? (rd_key <= key_q) : (rd_key < key_q);
  assign key_hit  = (rd_key == key_q);
  assign full     = (cnt_q >= FULL_C);

  assign req_i.ready            = (state_q == S_IDLE);
  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_status_q;
  assign rsp_o.selected_cluster = rsp_sel_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    cid_d        = cid_q;
    cnt_d        = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    idx_d        = idx_q;
    wp_d         = wp_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_sel_d    = res_sel_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_sel_d    = rsp_sel_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = rd_q;

    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d        = req_i.command;
          key_d        = req_i.key;
          cid_d        = cid_in;
          lo_d         = '0;
          hi_d         = cnt_q;
          idx_d        = '0;
          wp_d         = '0;
          pend_d       = 1'b0;
          res_sel_d    = '0;
          res_status_d = ST_OK;
          case (req_i.command)
            CMD_REGISTER, CMD_DEL_KEY: begin
              state_d = S_SEARCH;
            end
            CMD_SELECT: begin
              if (cnt_q == '0) begin
                res_status_d = ST_NOTFOUND;
                state_d      = S_DONE;
              end else begin
                state_d = S_SEARCH;
              end
            end
            CMD_DEL_CLUSTER: begin
              state_d = S_PURGE;
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            default: begin
              res_status_d = ST_NOTFOUND;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (lo_q < hi_q) begin
          mem_re    = 1'b1;
          mem_raddr = mid[AW-1:0];
          idx_d     = mid;
          state_d   = S_CMP;
        end else if (cmd_q == CMD_SELECT) begin
          mem_re    = 1'b1;
          mem_raddr = (lo_q >= cnt_q) ? '0 : lo_q[AW-1:0];
          state_d   = S_FETCH;
        end else if (lo_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = lo_q[AW-1:0];
          state_d   = S_FETCH;
        end else if (cmd_q == CMD_REGISTER) begin
          if (full) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            idx_d   = cnt_q;
            pend_d  = 1'b0;
            state_d = S_INSERT;
          end
        end else begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_DONE;
        end
      end

      S_CMP: begin
        if (go_right) begin
          lo_d = idx_q + ONE_C;
        end else begin
          hi_d = idx_q;
        end
        state_d = S_SEARCH;
      end

      S_FETCH: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_SELECT: begin
            res_sel_d = sel8;
          end
          CMD_REGISTER: begin
            if (key_hit) begin
              mem_we    = 1'b1;
              mem_waddr = lo_q[AW-1:0];
              mem_wdata = {key_q, cid_q};
            end else if (full) begin
              res_status_d = ST_FULL;
            end else begin
              idx_d   = cnt_q;
              pend_d  = 1'b0;
              state_d = S_INSERT;
            end
          end
          CMD_DEL_KEY: begin
            if (key_hit) begin
              idx_d   = lo_q + ONE_C;
              pend_d  = 1'b0;
              state_d = S_REMOVE;
            end else begin
              res_status_d = ST_NOTFOUND;
            end
          end
          default: begin
            res_status_d = ST_NOTFOUND;
          end
        endcase
      end

      // shift entries up from the top, then drop the new one at lo
      S_INSERT: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wp_q[AW-1:0];
          mem_wdata = rd_q;
        end
        if (idx_q > lo_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q - ONE_C);
          wp_d      = idx_q;
          idx_d     = idx_q - ONE_C;
          pend_d    = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = {key_q, cid_q};
          cnt_d     = cnt_q + ONE_C;
          state_d   = S_DONE;
        end
      end

      // shift entries above lo down by one
      S_REMOVE: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wp_q[AW-1:0];
          mem_wdata = rd_q;
        end
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          wp_d      = idx_q - ONE_C;
          idx_d     = idx_q + ONE_C;
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          cnt_d   = cnt_q - ONE_C;
          state_d = S_DONE;
        end
      end

      // compaction pass: keep entries of other clusters
      S_PURGE: begin
        if (pend_q && (rd_cid != cid_q)) begin
          mem_we    = 1'b1;
          mem_waddr = wp_q[AW-1:0];
          mem_wdata = rd_q;
          wp_d      = wp_q + ONE_C;
        end
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + ONE_C;
          pend_d    = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          res_status_d = (wp_q == cnt_q) ? ST_NOTFOUND : ST_OK;
          cnt_d        = wp_q;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_sel_d    = (res_status_q == ST_OK) ? res_sel_q : '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    cid_q        <= cid_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    idx_q        <= idx_d;
    wp_q         <= wp_d;
    res_status_q <= res_status_d;
    res_sel_q    <= res_sel_d;
    rsp_status_q <= rsp_status_d;
    rsp_sel_q    <= rsp_sel_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  `CHR_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FULL_C, "entry count overflow")
  `CHR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_i.ready,
                  state_q != S_IDLE, "sequencer idle after accept")
  `CHR_ASSERT_IMP(a_search_window, clk_i, rst_ni, state_q == S_SEARCH,
                  (lo_q <= hi_q) && (hi_q <= cnt_q), "search window out of range")
  `CHR_ASSERT_IMP(a_sel_zero, clk_i, rst_ni, rsp_valid_q && (rsp_status_q != ST_OK),
                  rsp_sel_q == '0, "cluster nonzero on failed item")

endmodule
